>>> hdl/sgpl_pkg.sv
// sgpl_pkg: shared constants, codes and types of the page list to descriptor block
// used by every module under hdl and by the port checker
package sgpl_pkg;

   // configuration of the block
   localparam int PAGE_BITS   = 12;
   localparam int MAX_SEGMENT = 65536;
   localparam int MAX_DESCS   = 128;

   // field widths
   localparam int FRAME_W  = 52;
   localparam int OFFSET_W = 12;
   localparam int TOTAL_W  = 32;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int ATTR_W   = 8;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;

   // derived widths
   localparam int FRAME_LO_W = ADDR_W - PAGE_BITS;
   localparam int FRAME_HI_W = FRAME_W - FRAME_LO_W;
   localparam int PAGES_W    = ADDR_W + 1 - PAGE_BITS;
   localparam int SEG_W      = 17;
   localparam int BOUND_W    = 16;
   localparam int DC_W       = 8;

   localparam logic [SEG_W-1:0] PG_SIZE     = SEG_W'(1) << PAGE_BITS;
   localparam logic [SEG_W-1:0] SEG_SPAN    = SEG_W'(1) << BOUND_W;
   localparam logic [SEG_W-1:0] MAX_SEG_C   = SEG_W'(MAX_SEGMENT);
   localparam logic [DC_W-1:0]  MAX_DESCS_C = DC_W'(MAX_DESCS);

   // queue sizes
   localparam int ITEM_DEPTH = 4;
   localparam int ITEM_PTR_W = $clog2(ITEM_DEPTH);
   localparam int ITEM_CNT_W = $clog2(ITEM_DEPTH + 1);
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // descriptor attributes
   localparam logic [ATTR_W-1:0] ATTR_TRAN = 8'h21;
   localparam logic [ATTR_W-1:0] ATTR_LAST = 8'h27;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HIGH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      RS_IDLE   = 3'b001,
      RS_ACTIVE = 3'b010,
      RS_HALT   = 3'b100
   } sgpl_rs_type;

   // a page request after decode
   typedef struct packed {
      logic                  first;
      logic [FRAME_LO_W-1:0] frame_lo;
      logic                  hi_zero;
      logic                  hi_one;
      logic [TOTAL_W-1:0]    total;
      logic [PAGES_W-1:0]    pages;
      logic [ADDR_W-1:0]     addr;
      logic [SEG_W-1:0]      cap;
      logic [SEG_W-1:0]      segb;
   } sgpl_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
      logic [ATTR_W-1:0]   attr;
      logic [STATUS_W-1:0] status;
      logic                last;
   } sgpl_rsp_type;

   // up to two results per page, second only with the first
   typedef struct packed {
      logic         v0;
      logic         v1;
      sgpl_rsp_type r0;
      sgpl_rsp_type r1;
   } sgpl_push_type;

endpackage

>>> hdl/sg_page_list_to_dma_descriptors.sv
// Page list to ADMA2 descriptor builder. One page request is taken per clock
// while the item queue has room: req_tuser marks the first page of a data
// request, which also carries the byte offset into that page and the total
// length. Physically consecutive pages are merged into 32-bit transfer
// descriptors, each capped at the maximum segment and at the next 64 KiB
// boundary; the final one is clamped to the bytes left and carries end and
// interrupt (rsp_tlast high). An address at or above 4 GiB or a full table ends
// the request with one error result (rsp_tuser nonzero, tdata zero, rsp_tlast
// high) and its remaining pages are dropped. A page that both closes a
// descriptor and ends the request gives two results, and results leave at one
// per cycle while rsp_tready is high. The engine holds pages while more than two
// results wait in the output buffer. The first result passes through the item
// queue and the output buffer. Depends on sgpl_pkg and the sgpl_* modules.
module sg_page_list_to_dma_descriptors (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // page_frame[51:0], first_offset[63:52], total_bytes[95:64]
   input  logic [sgpl_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_page
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // desc_address[31:0], desc_length[47:32], desc_attributes[55:48]
   output logic [sgpl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [sgpl_pkg::STATUS_W-1:0]   rsp_tuser,
   // last_of_request
   output logic                            rsp_tlast
);
   import sgpl_pkg::*;

   sgpl_item_type dec_item;
   sgpl_item_type q_item;
   logic          q_valid;
   logic          q_pop;
   logic          rsp_room;
   sgpl_push_type push;

   sgpl_front u_front (
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .item      (dec_item)
   );

   sgpl_item_queue u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (dec_item),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   sgpl_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_pop   (q_pop),
      .rsp_room   (rsp_room),
      .push       (push)
   );

   sgpl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (rsp_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hdl/sgpl_front.sv
// sgpl_front: decodes one page request into the values its segment would open with
// depends on sgpl_pkg
module sgpl_front (
   input  logic [sgpl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output sgpl_pkg::sgpl_item_type         item
);
   import sgpl_pkg::*;

   logic [FRAME_W-1:0]    frame;
   logic [OFFSET_W-1:0]   off_raw;
   logic [ADDR_W-1:0]     off_ext;
   logic [PAGE_BITS-1:0]  off;
   logic [TOTAL_W-1:0]    total;
   logic [FRAME_HI_W-1:0] frame_hi;
   logic [ADDR_W-1:0]     addr;
   logic [SEG_W-1:0]      bcap;
   logic [ADDR_W:0]       span_sum;

   assign frame    = req_tdata[FRAME_W-1:0];
   assign off_raw  = req_tdata[FRAME_W+OFFSET_W-1:FRAME_W];
   assign total    = req_tdata[FRAME_W+OFFSET_W+TOTAL_W-1:FRAME_W+OFFSET_W];
   assign off_ext  = ADDR_W'(off_raw);
   // offset counts only on the first page, taken modulo the page size
   assign off      = req_tuser ? off_ext[PAGE_BITS-1:0] : '0;
   assign frame_hi = frame[FRAME_W-1:FRAME_LO_W];
   assign addr     = {frame[FRAME_LO_W-1:0], off};
   // room left before the next 64 KiB boundary
   assign bcap     = SEG_SPAN - {1'b0, addr[BOUND_W-1:0]};
   assign span_sum = {1'b0, total} + (ADDR_W+1)'(off) + (ADDR_W+1)'(PG_SIZE - 1'b1);

   always_comb begin
      item.first    = req_tuser;
      item.frame_lo = frame[FRAME_LO_W-1:0];
      item.hi_zero  = (frame_hi == '0);
      item.hi_one   = (frame_hi == FRAME_HI_W'(1));
      item.total    = total;
      item.pages    = span_sum[ADDR_W:PAGE_BITS];
      item.addr     = addr;
      item.cap      = (MAX_SEG_C < bcap) ? MAX_SEG_C : bcap;
      item.segb     = PG_SIZE - SEG_W'(off);
   end

endmodule

>>> hdl/sgpl_item_queue.sv
// sgpl_item_queue: short queue of decoded page requests between front and engine
// depends on sgpl_pkg
module sgpl_item_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sgpl_pkg::sgpl_item_type in_item,
   output logic                    out_valid,
   output sgpl_pkg::sgpl_item_type out_item,
   input  logic                    out_pop
);
   import sgpl_pkg::*;

   sgpl_item_type         slot_ff [ITEM_DEPTH];
   logic [ITEM_PTR_W-1:0] wr_ff, wr_in;
   logic [ITEM_PTR_W-1:0] rd_ff, rd_in;
   logic [ITEM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (cnt_ff != ITEM_CNT_W'(ITEM_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_pop & out_valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + ITEM_CNT_W'(push) - ITEM_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end

endmodule

>>> hdl/sgpl_engine.sv
// sgpl_engine: per-request segment state; merges pages and closes descriptors
// depends on sgpl_pkg; feeds sgpl_rsp_buf
module sgpl_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  sgpl_pkg::sgpl_item_type item,
   output logic                    item_pop,
   input  logic                    rsp_room,
   output sgpl_pkg::sgpl_push_type push
);
   import sgpl_pkg::*;

   sgpl_rs_type           state_ff, state_in;
   logic [ADDR_W-1:0]     start_ff, start_in;
   logic [SEG_W-1:0]      segb_ff, segb_in;
   logic [SEG_W-1:0]      cap_ff, cap_in;
   logic [ADDR_W-1:0]     br_ff, br_in;
   logic [PAGES_W-1:0]    pages_ff, pages_in;
   logic [FRAME_LO_W-1:0] prev_ff;
   logic [DC_W-1:0]       dc_ff, dc_in;

   logic                  take, active;
   logic [FRAME_LO_W:0]   prev_inc;
   logic                  contig, fits, more, extend, close, open;
   logic [SEG_W-1:0]      seg_min, len1, tail_min;
   logic [ADDR_W-1:0]     br1, br_o;
   logic [DC_W-1:0]       dc_o;
   logic [PAGES_W-1:0]    p_o, pages_base;
   logic                  open_full, open_fail, step_ok, final_pg, over, tail_v;
   logic [STATUS_W-1:0]   fail_st;
   sgpl_rsp_type          desc1, tail;

   assign take     = item_valid & rsp_room;
   assign item_pop = take;
   assign active   = (state_ff == RS_ACTIVE);

   // merge test against the open segment
   assign prev_inc = {1'b0, prev_ff} + 1'b1;
   assign contig   = (item.frame_lo == prev_inc[FRAME_LO_W-1:0]) &&
                     (prev_inc[FRAME_LO_W] ? item.hi_one : item.hi_zero);
   assign fits     = ({1'b0, segb_ff} + {1'b0, PG_SIZE}) <= {1'b0, cap_ff};
   assign more     = ADDR_W'(segb_ff) < br_ff;

   assign extend = take & ~item.first & active & contig & fits & more;
   assign close  = take & ~item.first & active & ~(contig & fits & more);
   assign open   = (take & item.first) | close;

   // clamp of the segment being closed
   assign seg_min = (segb_ff < cap_ff) ? segb_ff : cap_ff;
   assign len1    = (br_ff < ADDR_W'(seg_min)) ? br_ff[SEG_W-1:0] : seg_min;
   assign br1     = br_ff - ADDR_W'(len1);

   assign br_o = item.first ? item.total : br1;
   assign dc_o = item.first ? '0 : dc_ff;
   assign p_o  = item.first ? item.pages : pages_ff;

   assign open_full = (br_o == '0) || (dc_o >= MAX_DESCS_C);
   assign open_fail = open & (open_full | ~item.hi_zero);
   assign fail_st   = open_full ? ST_FULL : ST_HIGH;
   assign step_ok   = (open & ~open_fail) | extend;

   always_comb begin
      start_in   = open ? item.addr : start_ff;
      cap_in     = open ? item.cap : cap_ff;
      segb_in    = open ? item.segb : segb_ff + PG_SIZE;
      br_in      = open ? br_o : br_ff;
      dc_in      = open ? dc_o + 1'b1 : dc_ff;
      pages_base = open ? p_o : pages_ff;
      pages_in   = (pages_base != '0) ? pages_base - 1'b1 : '0;
   end

   // last page: the remaining bytes must fit the open segment
   assign final_pg = step_ok & (pages_in == '0);
   assign tail_min = (segb_in < cap_in) ? segb_in : cap_in;
   assign over     = br_in > ADDR_W'(tail_min);
   assign tail_v   = open_fail | final_pg;

   always_comb begin
      desc1.addr   = start_ff;
      desc1.len    = len1[LEN_W-1:0];
      desc1.attr   = ATTR_TRAN;
      desc1.status = ST_OK;
      desc1.last   = 1'b0;

      tail.addr   = '0;
      tail.len    = '0;
      tail.attr   = '0;
      tail.status = ST_FULL;
      tail.last   = 1'b1;
      priority if (open_fail) begin
         tail.status = fail_st;
      end else if (!over) begin
         tail.addr   = start_in;
         tail.len    = br_in[LEN_W-1:0];
         tail.attr   = ATTR_LAST;
         tail.status = ST_OK;
      end

      push.v0 = close | tail_v;
      push.r0 = close ? desc1 : tail;
      push.v1 = close & tail_v;
      push.r1 = tail;
   end

   always_comb begin
      priority if (open_fail) begin
         state_in = RS_HALT;
      end else if (final_pg) begin
         state_in = over ? RS_HALT : RS_IDLE;
      end else if (step_ok) begin
         state_in = RS_ACTIVE;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ok) begin
         start_ff <= start_in;
         cap_ff   <= cap_in;
         segb_ff  <= segb_in;
         br_ff    <= br_in;
         pages_ff <= pages_in;
         dc_ff    <= dc_in;
         prev_ff  <= item.frame_lo;
      end
   end

endmodule

>>> hdl/sgpl_rsp_buf.sv
// sgpl_rsp_buf: result buffer taking up to two results a cycle, one out per cycle while rsp_tready is high
// depends on sgpl_pkg
module sgpl_rsp_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  sgpl_pkg::sgpl_push_type            push,
   output logic                               room,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sgpl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [sgpl_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast
);
   import sgpl_pkg::*;

   sgpl_rsp_type         slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0] wr_next;
   logic                 pop;
   sgpl_rsp_type         head;

   // room for a worst-case page, which gives two results
   assign room       = (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign rsp_tvalid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign rsp_tdata  = {head.attr, head.len, head.addr};
   assign rsp_tuser  = head.status;
   assign rsp_tlast  = head.last;
   assign pop        = rsp_tvalid & rsp_tready;
   assign wr_next    = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + RSP_PTR_W'(push.v0) + RSP_PTR_W'(push.v1);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + RSP_CNT_W'(push.v0) + RSP_CNT_W'(push.v1) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[wr_ff] <= push.r0;
      end
      if (push.v1) begin
         slot_ff[wr_next] <= push.r1;
      end
   end

endmodule

>>> hdl/sgpl_checker.sv
// sgpl_checker: port-level checks on the descriptor builder's result stream
// depends on sgpl_pkg; bound to sg_page_list_to_dma_descriptors below
module sgpl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sgpl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sgpl_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                            rsp_tlast
);
   import sgpl_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // error results carry no descriptor and end the request
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0 && rsp_tlast)
      else $error("malformed error result");

   // descriptor attributes follow the end-of-request mark
   a_attr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OK |->
         (rsp_tlast ? rsp_tdata[RSP_DATA_W-1:ADDR_W+LEN_W] == ATTR_LAST
                    : rsp_tdata[RSP_DATA_W-1:ADDR_W+LEN_W] == ATTR_TRAN))
      else $error("descriptor attributes do not match last mark");

   // only three status codes exist
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_HIGH || rsp_tuser == ST_FULL)
      else $error("unknown status code");

endmodule

bind sg_page_list_to_dma_descriptors sgpl_checker u_sgpl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
